// ----- rtl/upe_pkg.sv -----
`default_nettype none

package upe_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SET_0_63    = 3'd0,
        REG_SET_64_127  = 3'd1,
        REG_SET_128_191 = 3'd2,
        REG_SET_192_255 = 3'd3,
        REG_SPACE_PLUS  = 3'd4,
        REG_HEX_LOWER   = 3'd5
    } cfg_index_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned BYTE_W      = 8;

    // reset value of the allowed set: - . 0-9 A-Z _ a-z ~
    localparam logic [63:0] SET_0_63_RST    = 64'h03FF_6000_0000_0000;
    localparam logic [63:0] SET_64_127_RST  = 64'h47FF_FFFE_87FF_FFFE;
    localparam logic [63:0] SET_128_191_RST = 64'h0;
    localparam logic [63:0] SET_192_255_RST = 64'h0;

    // ascii codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [3:0] NIBBLE_MASK = 4'h0F;

    // escape character positions
    localparam logic [1:0] POS_PERCENT = 2'd0;
    localparam logic [1:0] POS_HIGH    = 2'd1;
    localparam logic [1:0] POS_LOW     = 2'd2;

    // live configuration
    typedef struct packed {
        logic [255:0] allowed;
        logic         space_to_plus;
        logic         hex_lowercase;
    } cfg_t;

    // one encoded byte, ready for serializing
    typedef struct packed {
        logic       esc;
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic [7:0] ch2;
        logic       last;
    } word_t;

    // ascii hex digit of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nib, input logic lower);
        logic [7:0] base;
        logic [7:0] wide;
        wide = {4'h0, nib & NIBBLE_MASK};
        if (nib < 4'd10)
        begin
            hex_digit = CH_ZERO + wide;
        end
        else
        begin
            base = lower ? CH_LOWER_A : CH_UPPER_A;
            hex_digit = base + wide - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/upe_cfg_regs.sv -----
`default_nettype none

module upe_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [upe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [upe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output upe_pkg::cfg_t                       cfg
);
    import upe_pkg::*;

    logic [255:0] allowed_reg;
    logic         space_plus_reg;
    logic         hex_lower_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allowed_reg    <= {SET_192_255_RST, SET_128_191_RST, SET_64_127_RST, SET_0_63_RST};
            space_plus_reg <= 1'b0;
            hex_lower_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_SET_0_63:    allowed_reg[63:0]    <= cfg_wdata;
                REG_SET_64_127:  allowed_reg[127:64]  <= cfg_wdata;
                REG_SET_128_191: allowed_reg[191:128] <= cfg_wdata;
                REG_SET_192_255: allowed_reg[255:192] <= cfg_wdata;
                REG_SPACE_PLUS:  space_plus_reg       <= cfg_wdata[0];
                REG_HEX_LOWER:   hex_lower_reg        <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    assign cfg.allowed       = allowed_reg;
    assign cfg.space_to_plus = space_plus_reg;
    assign cfg.hex_lowercase = hex_lower_reg;

endmodule

`default_nettype wire

// ----- rtl/upe_classify.sv -----
`default_nettype none

module upe_classify (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire upe_pkg::cfg_t                cfg,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [upe_pkg::BYTE_W-1:0]   in_byte,
    input  wire logic                         in_last,
    output logic                              word_valid,
    input  wire logic                         word_ready,
    output upe_pkg::word_t                    word
);
    import upe_pkg::*;

    // stage 1: set lookup
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       s1_allowed_reg;
    logic       s1_plus_reg;
    logic       s1_ready;

    // stage 2: encoded characters
    logic       s2_valid_reg;
    word_t      s2_word_reg;
    word_t      s2_word_next;
    logic       s2_ready;

    assign s2_ready = !s2_valid_reg || word_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_byte_reg    <= in_byte;
            s1_last_reg    <= in_last;
            s1_allowed_reg <= cfg.allowed[in_byte];
            s1_plus_reg    <= (in_byte == CH_SPACE) && cfg.space_to_plus;
        end
    end

    // choose pass-through, plus or escape
    always_comb
    begin
        s2_word_next.last = s1_last_reg;
        s2_word_next.ch1  = hex_digit(s1_byte_reg[7:4], cfg.hex_lowercase);
        s2_word_next.ch2  = hex_digit(s1_byte_reg[3:0], cfg.hex_lowercase);
        priority if (s1_allowed_reg)
        begin
            s2_word_next.esc = 1'b0;
            s2_word_next.ch0 = s1_byte_reg;
        end
        else if (s1_plus_reg)
        begin
            s2_word_next.esc = 1'b0;
            s2_word_next.ch0 = CH_PLUS;
        end
        else
        begin
            s2_word_next.esc = 1'b1;
            s2_word_next.ch0 = CH_PERCENT;
        end
    end

    // stage 2 payload
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_word_reg <= s2_word_next;
        end
    end

    assign word_valid = s2_valid_reg;
    assign word       = s2_word_reg;

endmodule

`default_nettype wire

// ----- rtl/upe_expand.sv -----
`default_nettype none

module upe_expand (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       word_valid,
    output logic                            word_ready,
    input  wire upe_pkg::word_t             word,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [upe_pkg::BYTE_W-1:0]      out_char,
    output logic                            run_last,
    output logic                            message_end
);
    import upe_pkg::*;

    // word being serialized
    logic       hold_valid_reg;
    word_t      hold_word_reg;
    logic [1:0] pos_reg;
    logic [1:0] pos_next;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic [7:0] out_char_next;
    logic       run_last_reg;
    logic       msg_end_reg;

    logic out_free;
    logic emit;
    logic final_char;

    assign out_free   = !out_valid_reg || out_ready;
    assign emit       = hold_valid_reg && out_free;
    assign final_char = !hold_word_reg.esc || (pos_reg == POS_LOW);
    assign word_ready = !hold_valid_reg || (emit && final_char);

    // character at the current position
    always_comb
    begin
        unique case (pos_reg)
            POS_PERCENT: out_char_next = hold_word_reg.ch0;
            POS_HIGH:    out_char_next = hold_word_reg.ch1;
            default:     out_char_next = hold_word_reg.ch2;
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (word_ready)
        begin
            pos_next = POS_PERCENT;
        end
        else if (emit)
        begin
            pos_next = pos_reg + 2'd1;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            pos_reg        <= POS_PERCENT;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (word_ready)
            begin
                hold_valid_reg <= word_valid;
            end
            pos_reg <= pos_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (word_ready && word_valid)
        begin
            hold_word_reg <= word;
        end
        if (emit)
        begin
            out_char_reg <= out_char_next;
            run_last_reg <= final_char;
            msg_end_reg  <= final_char && hold_word_reg.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign run_last    = run_last_reg;
    assign message_end = msg_end_reg;

endmodule

`default_nettype wire

// ----- rtl/url_percent_encoder_top.sv -----
// url percent encoder
//
// slave stream s_*: one raw byte per word, s_tlast marks the message's last byte.
// master stream m_*: one encoded character per word. an allowed byte gives one
// word, a disallowed space gives '+' when space-to-plus is on, any other byte
// gives '%' and two hex digits. m_tuser[0] flags the final character of each
// byte, m_tlast the final character of the message.
// configuration: cfg_we writes cfg_wdata to register cfg_index (0-3 allowed set,
// 4 space-to-plus, 5 lower-case hex); write only while the block is idle.
// path: the first character of a byte passes the lookup stage, the encode stage,
// the serializer and the output register before it shows on m_*.
// throughput: one character per cycle while m_tready is high, set by the
// single-character output port of the serializer; an escaped byte gives three.
// reset clears all valid bits and loads the unreserved set; no clearing pass.
// when m_tready is low the output word holds and the stages fill, after which
// s_tready drops; nothing is lost or repeated.
`default_nettype none

module url_percent_encoder_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // last_byte
    // output stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_char
    output logic [0:0]      m_tuser,   // [0] run_last
    output logic            m_tlast,   // message_end
    // configuration
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [63:0] cfg_wdata
);
    import upe_pkg::*;

    cfg_t  cfg;
    logic  word_valid;
    logic  word_ready;
    word_t word;
    logic  run_last;

    upe_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    upe_classify u_classify (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word       (word)
    );

    upe_expand u_expand (
        .clk         (clk),
        .rst_n       (rst_n),
        .word_valid  (word_valid),
        .word_ready  (word_ready),
        .word        (word),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_char    (m_tdata),
        .run_last    (run_last),
        .message_end (m_tlast)
    );

    assign m_tuser[0] = run_last;

`ifndef SYNTH
    // message end only on the final character of a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tlast || m_tuser[0]))
        else $error("message end without run end");

    // an escape streams its three characters without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tuser[0]) |=> m_tvalid)
        else $error("gap inside an escape sequence");

    // encoded word waits unchanged for the serializer
    assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid && !word_ready) |=> (word_valid && $stable(word)))
        else $error("encoded word lost while stalled");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import upe_pkg::*;

    // indexes past the register list, writes there must change nothing
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    localparam logic [127:0] HEX_UPPER = "0123456789ABCDEF";
    localparam logic [127:0] HEX_LOWER = "0123456789abcdef";

    localparam int TAIL_CYCLES = 8;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 200000;

    // one encoded character as it should leave the block
    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       msg_end;
    } enc_char_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_wdata;

    // local copy of the encoder configuration
    logic [255:0] allowed_chars;
    logic         plus_for_space;
    logic         lower_hex;

    enc_char_t pending_chars[$];

    int  fail_count;
    int  bytes_sent;
    int  chars_checked;
    int  settings_used;
    int  cycle_count;
    bit  tx_gaps_on;
    bit  rx_stalls_on;
    int  rx_hold_cycles;

    url_percent_encoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock, 10 ns period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ascii hex digit for one nibble under the current case setting
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [127:0] digits;
        digits = lower_hex ? HEX_LOWER : HEX_UPPER;
        return digits[(15 - nib) * 8 +: 8];
    endfunction

    // queue the characters one raw byte turns into
    function automatic void encode_byte(input logic [7:0] b, input logic last);
        if (allowed_chars[b])
        begin
            pending_chars.push_back('{ch: b, run_last: 1'b1, msg_end: last});
        end
        else if (b == CH_SPACE && plus_for_space)
        begin
            pending_chars.push_back('{ch: CH_PLUS, run_last: 1'b1, msg_end: last});
        end
        else
        begin
            pending_chars.push_back('{ch: CH_PERCENT, run_last: 1'b0, msg_end: 1'b0});
            pending_chars.push_back('{ch: hex_char(b[7:4]), run_last: 1'b0, msg_end: 1'b0});
            pending_chars.push_back('{ch: hex_char(b[3:0]), run_last: 1'b1, msg_end: last});
        end
    endfunction

    // register write, mirrored into the local configuration
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_SET_0_63:    allowed_chars[63:0]    = value;
            REG_SET_64_127:  allowed_chars[127:64]  = value;
            REG_SET_128_191: allowed_chars[191:128] = value;
            REG_SET_192_255: allowed_chars[255:192] = value;
            REG_SPACE_PLUS:  plus_for_space         = value[0];
            REG_HEX_LOWER:   lower_hex              = value[0];
            default:         ;
        endcase
    endtask

    task automatic write_all_regs(input logic [255:0] chars, input logic plus,
                                  input logic lower);
        write_reg(REG_SET_0_63, chars[63:0]);
        write_reg(REG_SET_64_127, chars[127:64]);
        write_reg(REG_SET_128_191, chars[191:128]);
        write_reg(REG_SET_192_255, chars[255:192]);
        write_reg(REG_SPACE_PLUS, {$urandom, $urandom} & ~64'h1 | 64'(plus));
        write_reg(REG_HEX_LOWER, {$urandom, $urandom} & ~64'h1 | 64'(lower));
        settings_used++;
    endtask

    // offer one byte and wait for the block to take it
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 8) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        encode_byte(b, last);
        bytes_sent++;
    endtask

    // stop sending and let every queued character come out
    task automatic wait_encoder_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] random_byte();
        if ($urandom_range(0, 7) == 0)
            return CH_SPACE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic random_last();
        return ($urandom_range(0, 5) == 0);
    endfunction

    task automatic send_random_bytes(input int count);
        repeat (count) send_byte(random_byte(), random_last());
    endtask

    // receiver: random stall before each word, plus the long hold on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            int stall;
            if (rx_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge clk);
                rx_hold_cycles = 0;
            end
            stall = rx_stalls_on ? $urandom_range(0, 8) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid && rx_hold_cycles == 0);
            @(negedge clk);
        end
    end

    // compare each character that leaves the block with the oldest one queued
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            enc_char_t want;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected word: out_char %h run_last %b message_end %b",
                       m_tdata, m_tuser[0], m_tlast);
                fail_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (m_tdata !== want.ch)
                begin
                    $error("out_char: expected %h, got %h", want.ch, m_tdata);
                    fail_count++;
                end
                if (m_tuser[0] !== want.run_last)
                begin
                    $error("run_last: expected %b, got %b", want.run_last, m_tuser[0]);
                    fail_count++;
                end
                if (m_tlast !== want.msg_end)
                begin
                    $error("message_end: expected %b, got %b", want.msg_end, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // reset set: letters, digits, marks, space, control and high bytes
    task automatic test_reset_defaults();
        logic [7:0] probe[$];
        probe = '{"a", "z", "A", "Z", "0", "9", "-", ".", "_", "~", " ",
                  8'h00, 8'hFF, "%", "+", 8'h80};
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        foreach (probe[i])
            send_byte(probe[i], probe[i] == "~" || probe[i] == 8'hFF);
        wait_encoder_idle();
    endtask

    // plus for space, lower-case hex, allowed space, spare indexes, wide values
    task automatic test_config_options();
        write_reg(REG_SPACE_PLUS, 64'h1);
        write_reg(REG_HEX_LOWER, 64'h1);
        settings_used++;
        send_byte(" ", 1'b0);
        send_byte(8'hAB, 1'b0);
        send_byte(8'hFE, 1'b1);
        wait_encoder_idle();

        // an allowed space passes even with plus on
        write_reg(REG_SET_0_63, SET_0_63_RST | 64'h1 << CH_SPACE);
        send_byte(" ", 1'b1);
        wait_encoder_idle();

        write_reg(REG_SET_0_63, SET_0_63_RST);
        write_reg(REG_SPARE_6, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_SPARE_7, 64'h5555_AAAA_5555_AAAA);
        write_reg(REG_SPACE_PLUS, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(REG_HEX_LOWER, 64'h8000_0000_0000_0001);
        settings_used++;
        send_byte(" ", 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte("x", 1'b1);
        wait_encoder_idle();
    endtask

    // empty set and full set
    task automatic test_set_extremes();
        write_all_regs('0, 1'b1, 1'b0);
        send_random_bytes(20);
        wait_encoder_idle();
        write_all_regs('1, 1'b1, 1'b1);
        send_random_bytes(20);
        wait_encoder_idle();
    endtask

    // random sets and options, idling on or off per phase
    task automatic test_random_settings();
        for (int phase = 0; phase < 4; phase++)
        begin
            write_all_regs({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom}, 1'($urandom), 1'($urandom));
            tx_gaps_on   = (phase != 2);
            rx_stalls_on = (phase != 2);
            send_random_bytes(30);
            wait_encoder_idle();
        end
    endtask

    // receiver holds off while the sender streams without gaps
    task automatic test_back_pressure();
        write_all_regs({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom} & {8{32'h0F0F_0F0F}}, 1'b1, 1'b0);
        tx_gaps_on     = 1'b0;
        rx_stalls_on   = 1'b1;
        rx_hold_cycles = HOLD_CYCLES;
        send_random_bytes(25);
        wait_encoder_idle();
    endtask

    // back to the reset set, full rate both sides
    task automatic test_full_rate();
        write_all_regs({SET_192_255_RST, SET_128_191_RST, SET_64_127_RST, SET_0_63_RST},
                       1'b0, 1'b0);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        send_random_bytes(25);
        wait_encoder_idle();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        fail_count     = 0;
        bytes_sent     = 0;
        chars_checked  = 0;
        settings_used  = 1;
        cycle_count    = 0;
        tx_gaps_on     = 1'b1;
        rx_stalls_on   = 1'b1;
        rx_hold_cycles = 0;
        allowed_chars  = {SET_192_255_RST, SET_128_191_RST, SET_64_127_RST, SET_0_63_RST};
        plus_for_space = 1'b0;
        lower_hex      = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_config_options();
        test_set_extremes();
        test_random_settings();
        test_back_pressure();
        test_full_rate();

        if (pending_chars.size() != 0)
        begin
            $error("%0d characters never came out", pending_chars.size());
            fail_count++;
        end
        $display("tb_top: %0d bytes encoded into %0d checked characters", bytes_sent,
                 chars_checked);
        $display("tb_top: %0d register settings, including empty and full sets", settings_used);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
